@@ sv/twcr_pkg.sv @@
// Shared types, constants and helpers for the textured wall column rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package twcr_pkg;

    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int COORD_W     = 32;
    localparam int DIST_W      = 31;
    localparam int HEIGHT_W    = 16;
    localparam int SIZE_W      = 11;
    localparam int COLOR_W     = 24;
    localparam int TEXEL_W     = 10;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int S_DATA_W = 216;
    localparam int M_DATA_W = 72;

    localparam int OFS_COLUMN = 0;
    localparam int OFS_SIDE   = 12;
    localparam int OFS_EYE_X  = 13;
    localparam int OFS_EYE_Y  = 45;
    localparam int OFS_DIST   = 77;
    localparam int OFS_DIR_X  = 108;
    localparam int OFS_DIR_Y  = 140;
    localparam int OFS_WH     = 172;
    localparam int OFS_TOP    = 188;
    localparam int OFS_BOTTOM = 200;

    localparam int OFS_OUT_COLUMN = 0;
    localparam int OFS_OUT_ROW    = 12;
    localparam int OFS_FLAT       = 24;
    localparam int OFS_TEXEL_COL  = 48;
    localparam int OFS_TEXEL_ROW  = 58;

    localparam int NUM_W     = 27;
    localparam int DIV_STEPS = 27;
    localparam int DIV_CNT_W = 5;
    localparam int START_W   = 18;
    localparam int SCALE_W   = START_W + NUM_W + 1;

    localparam int SCREEN_ROWS_DEFAULT = 512;

    localparam logic [0:0] CMD_START = 1'b0;
    localparam logic [0:0] CMD_ROW   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_SKY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GROUND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXEL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKY        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUND     = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 11'd1024;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic scale;
        logic place;
        logic emit;
    } twcr_cmd_t;

    typedef struct packed {
        logic div_last;
        logic last_row;
        logic out_free;
    } twcr_sts_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = 11'd1;
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/textured_wall_column_raster.sv @@
// Top level of the textured wall column rasterizer.
// A start word (tuser 0) loads one column's ray hit: it captures the hit and forms distance *
// direction, and the input then stays stalled while the texture column is found, the radix-2
// divider forms the Q11.16 texture step, the start offset is scaled by the step and then
// saturated. A row word (tuser 1) then yields one pixel, rows 0 to SCREEN_ROWS-1, with tlast on
// the last row; row words outside an active column are dropped. A pixel waits in the output
// register, and no input word is taken while it stalls. Configuration writes are taken every
// cycle.
`timescale 1ns / 1ps
`default_nettype none
module textured_wall_column_raster #(
    parameter int SCREEN_ROWS = twcr_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // screen_column, hit_side, eye_x, eye_y, wall_distance, dir_x, dir_y, wall_height,
    // wall_top, wall_bottom, zero pad
    input  wire logic [twcr_pkg::S_DATA_W-1:0]     s_tdata,
    // command
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [twcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [twcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_column, out_row, flat_color, texel_col, texel_row, zero pad
    output logic [twcr_pkg::M_DATA_W-1:0]          m_tdata,
    // pixel_kind
    output logic [twcr_pkg::KIND_W-1:0]            m_tuser,
    output logic                                   m_tlast
);
    import twcr_pkg::*;

    twcr_cmd_t cmd;
    twcr_sts_t sts;

    twcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    twcr_datapath #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

@@ sv/twcr_ctrl.sv @@
// Sequencer for column setup, serial divide and row emission.
`timescale 1ns / 1ps
`default_nettype none
module twcr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    input  wire twcr_pkg::twcr_sts_t  sts,
    output logic                      s_tready,
    output twcr_pkg::twcr_cmd_t       cmd
);
    import twcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SCALE,
        ST_PLACE,
        ST_ACTIVE
    } state_t;

    state_t state_reg, state_next;
    logic   s_fire;

    assign s_tready = ((state_reg == ST_IDLE) || (state_reg == ST_ACTIVE)) && sts.out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = s_fire && (s_tuser == CMD_START);
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_ACTIVE;
            end
            ST_ACTIVE: begin
                if (cmd.capture) begin
                    state_next = ST_PREP;
                end else if (s_fire) begin
                    cmd.emit = 1'b1;
                    if (sts.last_row) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/twcr_datapath.sv @@
// Registers, multipliers, radix-2 divider and pixel output stage.
`timescale 1ns / 1ps
`default_nettype none
module twcr_datapath #(
    parameter int SCREEN_ROWS = twcr_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire twcr_pkg::twcr_cmd_t                 cmd,
    output twcr_pkg::twcr_sts_t                      sts,
    input  wire logic [twcr_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [twcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [twcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [twcr_pkg::M_DATA_W-1:0]            m_tdata,
    output logic [twcr_pkg::KIND_W-1:0]              m_tuser,
    output logic                                     m_tlast
);
    import twcr_pkg::*;

    localparam int              HALF_ROWS = SCREEN_ROWS / 2;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] POS_MIN = 32'h8000_0000;

    logic [SIZE_W-1:0]  tex_w_reg, tex_h_reg, w_eff, h_eff;
    logic [COLOR_W-1:0] sky_reg, ground_reg;

    logic [COL_W-1:0]    in_column;
    logic                in_side;
    logic [COORD_W-1:0]  in_eye_x, in_eye_y, in_dir_x, in_dir_y, dir_sel, hit_prod;
    logic [DIST_W-1:0]   in_dist;
    logic [HEIGHT_W-1:0] in_wh, wh_eff;
    logic [ROW_W-1:0]    in_top, in_bottom;
    logic                mirror;
    logic signed [START_W-1:0] start_val;

    logic [COL_W-1:0]    column_reg;
    logic                mirror_reg;
    logic [COORD_W-1:0]  hit_prod_reg;
    logic [15:0]         eye_lo_reg;
    logic [HEIGHT_W-1:0] wh_reg;
    logic signed [START_W-1:0] start_reg;
    logic [ROW_W-1:0]    top_reg, bottom_reg, row_reg;
    logic [TEXEL_W-1:0]  texel_col_reg;

    logic [15:0]         frac;
    logic [26:0]         col_prod;
    logic [SIZE_W-1:0]   col_raw, col_mir;

    logic [HEIGHT_W-1:0] rem_reg;
    logic [NUM_W-1:0]    num_reg, quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [HEIGHT_W:0]   rem_sh, rem_sub;
    logic                rem_ge;

    logic signed [SCALE_W-1:0] scale_prod, scale_reg;
    logic                scale_fits;
    logic [COORD_W-1:0]  pos_sat, pos_reg;
    logic [COORD_W:0]    pos_sum;

    logic [SIZE_W-1:0]   h_top;
    logic [14:0]         ty_raw;
    logic [SIZE_W-1:0]   ty;

    logic                out_valid_reg, out_last_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [COL_W-1:0]    out_column_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COLOR_W-1:0]  out_flat_reg;
    logic [TEXEL_W-1:0]  out_tcol_reg, out_trow_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_w_reg  <= SIZE_RESET;
            tex_h_reg  <= SIZE_RESET;
            sky_reg    <= '0;
            ground_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TEX_WIDTH:  tex_w_reg  <= cfg_data[SIZE_W-1:0];
                CFG_TEX_HEIGHT: tex_h_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SKY:        sky_reg    <= cfg_data;
                CFG_GROUND:     ground_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_eff = eff_size(tex_w_reg);
    assign h_eff = eff_size(tex_h_reg);

    assign in_column = s_tdata[OFS_COLUMN +: COL_W];
    assign in_side   = s_tdata[OFS_SIDE];
    assign in_eye_x  = s_tdata[OFS_EYE_X +: COORD_W];
    assign in_eye_y  = s_tdata[OFS_EYE_Y +: COORD_W];
    assign in_dist   = s_tdata[OFS_DIST +: DIST_W];
    assign in_dir_x  = s_tdata[OFS_DIR_X +: COORD_W];
    assign in_dir_y  = s_tdata[OFS_DIR_Y +: COORD_W];
    assign in_wh     = s_tdata[OFS_WH +: HEIGHT_W];
    assign in_top    = s_tdata[OFS_TOP +: ROW_W];
    assign in_bottom = s_tdata[OFS_BOTTOM +: ROW_W];

    // only the low word of distance * direction reaches the fraction
    assign wh_eff    = (in_wh == '0) ? 16'd1 : in_wh;
    assign dir_sel   = in_side ? in_dir_x : in_dir_y;
    assign hit_prod  = {1'b0, in_dist} * dir_sel;
    assign mirror    = (!in_side && in_dir_x[COORD_W-1])
                    || (in_side && !in_dir_y[COORD_W-1] && (in_dir_y != '0));
    assign start_val = $signed({6'b0, in_top}) + $signed({3'b0, wh_eff[HEIGHT_W-1:1]})
                     - START_W'(HALF_ROWS);

    assign frac     = hit_prod_reg[31:16] + eye_lo_reg;
    assign col_prod = {11'b0, frac} * {16'b0, w_eff};
    assign col_raw  = col_prod[26:16];
    assign col_mir  = w_eff - col_raw - 11'd1;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, wh_reg};
    assign rem_ge  = (rem_sh >= {1'b0, wh_reg});

    assign scale_prod = start_reg * $signed({1'b0, quo_reg});
    assign scale_fits = (&scale_reg[SCALE_W-1:COORD_W-1]) || !(|scale_reg[SCALE_W-1:COORD_W-1]);
    assign pos_sat    = scale_fits ? scale_reg[COORD_W-1:0]
                      : (scale_reg[SCALE_W-1] ? POS_MIN : POS_MAX);

    assign pos_sum = {pos_reg[COORD_W-1], pos_reg} + {6'b0, quo_reg};

    assign h_top  = h_eff - 11'd1;
    assign ty_raw = pos_reg[30:16];
    assign ty     = pos_reg[COORD_W-1] ? '0
                  : ((ty_raw > {4'b0, h_top}) ? h_top : ty_raw[SIZE_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else if (cmd.capture) begin
            row_reg <= '0;
        end else if (cmd.emit) begin
            row_reg <= (row_reg >= LAST_ROW) ? '0 : row_reg + 12'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            column_reg   <= in_column;
            mirror_reg   <= mirror;
            hit_prod_reg <= hit_prod;
            eye_lo_reg   <= in_side ? in_eye_x[15:0] : in_eye_y[15:0];
            wh_reg       <= wh_eff;
            start_reg    <= start_val;
            top_reg      <= in_top;
            bottom_reg   <= in_bottom;
        end
        if (cmd.prep) begin
            texel_col_reg <= mirror_reg ? col_mir[TEXEL_W-1:0] : col_raw[TEXEL_W-1:0];
            rem_reg       <= '0;
            num_reg       <= {h_eff, 16'b0};
            quo_reg       <= '0;
            div_cnt_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_ge ? rem_sub[HEIGHT_W-1:0] : rem_sh[HEIGHT_W-1:0];
            num_reg     <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg     <= {quo_reg[NUM_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
        if (cmd.scale) begin
            scale_reg <= scale_prod;
        end
        if (cmd.place) begin
            pos_reg <= pos_sat;
        end
        if (cmd.emit && (row_reg >= top_reg) && (row_reg <= bottom_reg)) begin
            pos_reg <= (pos_sum[COORD_W] != pos_sum[COORD_W-1]) ? POS_MAX
                     : pos_sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_column_reg <= column_reg;
            out_row_reg    <= row_reg;
            out_last_reg   <= (row_reg >= LAST_ROW);
            if (row_reg < top_reg) begin
                out_kind_reg <= KIND_SKY;
                out_flat_reg <= sky_reg;
                out_tcol_reg <= '0;
                out_trow_reg <= '0;
            end else if (row_reg <= bottom_reg) begin
                out_kind_reg <= KIND_TEXEL;
                out_flat_reg <= '0;
                out_tcol_reg <= texel_col_reg;
                out_trow_reg <= ty[TEXEL_W-1:0];
            end else begin
                out_kind_reg <= KIND_GROUND;
                out_flat_reg <= ground_reg;
                out_tcol_reg <= '0;
                out_trow_reg <= '0;
            end
        end
    end

    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.last_row = (row_reg >= LAST_ROW);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_trow_reg, out_tcol_reg, out_flat_reg, out_row_reg,
                       out_column_reg};

endmodule
`default_nettype wire

@@ sv/twcr_checker.sv @@
// Port-level assertions for the rasterizer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module twcr_checker #(
    parameter int SCREEN_ROWS = twcr_pkg::SCREEN_ROWS_DEFAULT
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [twcr_pkg::M_DATA_W-1:0]     m_tdata,
    input wire logic [twcr_pkg::KIND_W-1:0]       m_tuser,
    input wire logic                              m_tlast
);
    import twcr_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

    a_setup_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_START) |=> !s_tready)
        else $error("input taken during column setup");

    a_flat_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_TEXEL)
        |-> m_tdata[OFS_TEXEL_ROW + TEXEL_W - 1:OFS_TEXEL_COL] == '0)
        else $error("texel fields set on a flat pixel");

    a_texel_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_TEXEL) |-> m_tdata[OFS_FLAT +: COLOR_W] == '0)
        else $error("color set on a texel pixel");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[OFS_OUT_ROW +: ROW_W] == LAST_ROW))
        else $error("tlast does not match the last row");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled pixel changed");

endmodule

bind textured_wall_column_raster twcr_checker #(
    .SCREEN_ROWS (SCREEN_ROWS)
) u_twcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
